### hw/rtl/breakpoint_table_manager_defines.svh
// assertion macros used by the breakpoint table controller rtl
`ifndef BREAKPOINT_TABLE_MANAGER_DEFINES_SVH
`define BREAKPOINT_TABLE_MANAGER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BPTM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BPTM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bptm_pkg.sv
package bptm_pkg;

    // command codes
    localparam logic [2:0] KIND_ADD         = 3'd0;
    localparam logic [2:0] KIND_CLEAR_SLOT  = 3'd1;
    localparam logic [2:0] KIND_CLEAR_TEMP  = 3'd2;
    localparam logic [2:0] KIND_FIND        = 3'd3;
    localparam logic [2:0] KIND_HIDE_ALL    = 3'd4;
    localparam logic [2:0] KIND_REFRESH_ALL = 3'd5;
    localparam logic [2:0] KIND_CLEAR_ALL   = 3'd6;
    localparam logic [2:0] KIND_UNUSED      = 3'd7;

    // add status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE  = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;
    localparam logic [1:0] STATUS_UNREADABLE = 2'd3;

    // flag bit positions and trap opcode
    localparam int unsigned FLAG_TMP = 0;
    localparam int unsigned FLAG_DIS = 1;
    localparam logic [7:0] TRAP_BYTE = 8'hCC;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] address;
        logic [7:0]  slot;
        logic [1:0]  attr_flags;
        logic        readable;
        logic [7:0]  current_byte;
    } in_item_t;

    typedef struct packed {
        logic        is_write;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  status;
        logic        found;
        logic [3:0]  index;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  saved_byte;
        logic [1:0]  flags;
    } entry_t;

endpackage

### hw/rtl/bptm_table.sv
module bptm_table #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  bptm_pkg::entry_t    wdata,
    input  logic                re,
    input  logic [IDX_W-1:0]    raddr,
    output bptm_pkg::entry_t    rdata
);

    bptm_pkg::entry_t mem [ENTRIES];
    bptm_pkg::entry_t rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bptm_ctrl.sv
`include "breakpoint_table_manager_defines.svh"

module bptm_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bptm_pkg::in_item_t   s_data,
    input  logic                 out_free,
    output logic                 out_push,
    output bptm_pkg::out_item_t  out_item,
    output logic                 tbl_we,
    output logic [IDX_W-1:0]     tbl_waddr,
    output bptm_pkg::entry_t     tbl_wdata,
    output logic                 tbl_re,
    output logic [IDX_W-1:0]     tbl_raddr,
    input  bptm_pkg::entry_t     tbl_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t             state_reg, state_next;
    bptm_pkg::in_item_t cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               single_reg, single_next;
    logic [1:0]         status_reg, status_next;
    logic               found_reg, found_next;
    logic [3:0]         index_reg, index_next;
    logic [ENTRIES-1:0] occ_reg, occ_next;

    logic cur_occ;
    logic addr_match;
    logic emit;
    logic clr;
    logic stop;
    logic last_entry;
    logic in_range;
    logic we_legal;
    logic status_beat;

    // shared compare unit on the entry under evaluation
    assign cur_occ    = occ_reg[idx_reg];
    assign addr_match = cur_occ && (tbl_rdata.address == cmd_reg.address);
    assign last_entry = single_reg || (idx_reg == LAST_IDX);
    assign in_range   = (32'(s_data.slot) < ENTRIES);

    // per-entry decision for the current command
    always_comb begin
        emit = 1'b0;
        clr  = 1'b0;
        stop = 1'b0;
        case (cmd_reg.kind)
            bptm_pkg::KIND_ADD: begin
                stop = !cur_occ || addr_match;
            end
            bptm_pkg::KIND_FIND: begin
                stop = addr_match;
            end
            bptm_pkg::KIND_CLEAR_SLOT, bptm_pkg::KIND_CLEAR_ALL: begin
                emit = cur_occ;
                clr  = cur_occ;
            end
            bptm_pkg::KIND_CLEAR_TEMP: begin
                emit = cur_occ && tbl_rdata.flags[bptm_pkg::FLAG_TMP];
                clr  = emit;
            end
            bptm_pkg::KIND_HIDE_ALL: begin
                emit = cur_occ;
            end
            bptm_pkg::KIND_REFRESH_ALL: begin
                emit = cur_occ && !tbl_rdata.flags[bptm_pkg::FLAG_DIS];
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        single_next = single_reg;
        status_next = status_reg;
        found_next  = found_reg;
        index_next  = index_reg;
        occ_next    = occ_reg;
        s_ready     = 1'b0;
        out_push    = 1'b0;
        out_item    = '0;
        tbl_we      = 1'b0;
        tbl_waddr   = idx_reg;
        tbl_wdata   = '{address: cmd_reg.address, saved_byte: cmd_reg.current_byte,
                        flags: cmd_reg.attr_flags};
        tbl_re      = 1'b0;
        tbl_raddr   = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next    = s_data;
                    status_next = bptm_pkg::STATUS_OK;
                    found_next  = 1'b0;
                    index_next  = '0;
                    single_next = (s_data.kind == bptm_pkg::KIND_CLEAR_SLOT);
                    idx_next    = (s_data.kind == bptm_pkg::KIND_CLEAR_SLOT) ?
                                  s_data.slot[IDX_W-1:0] : '0;
                    if (s_data.kind == bptm_pkg::KIND_UNUSED ||
                        (s_data.kind == bptm_pkg::KIND_FIND && s_data.address == '0) ||
                        (s_data.kind == bptm_pkg::KIND_CLEAR_SLOT && !in_range)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                tbl_re     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // hold on this entry while a write beat cannot be taken
                if (!(emit && !out_free)) begin
                    if (emit) begin
                        out_push               = 1'b1;
                        out_item.is_write      = 1'b1;
                        out_item.write_address = tbl_rdata.address;
                        out_item.write_data    =
                            (cmd_reg.kind == bptm_pkg::KIND_REFRESH_ALL) ?
                            bptm_pkg::TRAP_BYTE : tbl_rdata.saved_byte;
                    end
                    if (clr) begin
                        occ_next[idx_reg] = 1'b0;
                    end
                    if (cmd_reg.kind == bptm_pkg::KIND_ADD) begin
                        if (addr_match) begin
                            status_next = bptm_pkg::STATUS_DUPLICATE;
                        end else if (!cur_occ) begin
                            if (!cmd_reg.readable) begin
                                status_next = bptm_pkg::STATUS_UNREADABLE;
                            end else if (cmd_reg.address != '0) begin
                                tbl_we            = 1'b1;
                                occ_next[idx_reg] = 1'b1;
                            end
                        end else if (last_entry) begin
                            status_next = bptm_pkg::STATUS_FULL;
                        end
                    end
                    if (cmd_reg.kind == bptm_pkg::KIND_FIND && addr_match) begin
                        found_next = 1'b1;
                        index_next = 4'(idx_reg);
                    end
                    if (stop || last_entry) begin
                        state_next = ST_DONE;
                    end else begin
                        // advance and prefetch the next entry
                        idx_next  = idx_reg + IDX_W'(1);
                        tbl_re    = 1'b1;
                        tbl_raddr = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_push        = 1'b1;
                    out_item.status = status_reg;
                    out_item.found  = found_reg;
                    out_item.index  = index_reg;
                    out_item.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, occupancy and command registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        single_reg <= single_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    // terms for the checks below
    assign we_legal    = (cmd_reg.kind == bptm_pkg::KIND_ADD) && cmd_reg.readable &&
                         (state_reg == ST_EVAL);
    assign status_beat = out_push && out_item.last;

    `BPTM_ASSERT_IMP(a_push_free, aclk, aresetn, out_push, out_free, "beat pushed into busy output")
    `BPTM_ASSERT_IMP(a_we_add, aclk, aresetn, tbl_we, we_legal, "table write outside add")
    `BPTM_ASSERT_NXT(a_last_idle, aclk, aresetn, status_beat, s_ready, "not idle after status")

endmodule

### hw/rtl/breakpoint_table_manager.sv
// Breakpoint table manager: a table of ENTRIES software breakpoints.
// Input channel s_valid/s_ready/s_data carries one command beat (add, clear
// slot, clear temporaries, find, hide all, refresh all, clear all).
// Result channel m_valid/m_ready/m_data returns zero or more memory write
// beats (is_write set) followed by exactly one status beat with last set.
// s_ready is high only while the sequencer is idle; one command is handled
// at a time by a single compare unit that walks the entry memory.
// Steps: take the command while idle, read the first table entry, then
// decide each entry visited (up to ENTRIES) while prefetching the next
// entry, then push the status beat. A full scan visits every entry;
// add and find stop early.
// Each result goes into a single output register; while the receiver stalls
// the walk holds on the entry whose write beat is waiting.
// Reset clears the occupancy bits, so the table starts empty
// and the block is ready right after reset.
module breakpoint_table_manager #(
    parameter int ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bptm_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bptm_pkg::out_item_t  m_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                m_valid_reg;
    bptm_pkg::out_item_t m_data_reg;
    logic                out_free;
    logic                out_push;
    bptm_pkg::out_item_t out_item;
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    bptm_pkg::entry_t    tbl_wdata;
    logic                tbl_re;
    logic [IDX_W-1:0]    tbl_raddr;
    bptm_pkg::entry_t    tbl_rdata;

    bptm_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bptm_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .out_push  (out_push),
        .out_item  (out_item),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_re    (tbl_re),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata)
    );

    // output register, free when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (out_push) begin
            m_data_reg <= out_item;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### verif/bptm_checker.sv
module bptm_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  bptm_pkg::in_item_t   s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  bptm_pkg::out_item_t  m_data,
    output int unsigned          mismatch_count,
    output int unsigned          pending_count,
    output int unsigned          command_count,
    output int unsigned          write_count
);

    // shadow copy of the breakpoint table
    logic [31:0] bp_address [ENTRIES];
    logic [7:0]  bp_saved   [ENTRIES];
    logic [1:0]  bp_flags   [ENTRIES];

    // beats still owed by the block, oldest first
    bptm_pkg::out_item_t expected_beats [$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        command_count  = 0;
        write_count    = 0;
    end

    // one memory write beat
    function automatic bptm_pkg::out_item_t write_beat(logic [31:0] addr, logic [7:0] data);
        bptm_pkg::out_item_t b;
        b = '0;
        b.is_write      = 1'b1;
        b.write_address = addr;
        b.write_data    = data;
        return b;
    endfunction

    // restore the saved byte and empty the entry, if occupied
    function automatic void clear_breakpoint(int i);
        if (bp_address[i] != '0) begin
            expected_beats.push_back(write_beat(bp_address[i], bp_saved[i]));
            bp_address[i] = '0;
            bp_saved[i]   = '0;
            bp_flags[i]   = '0;
        end
    endfunction

    // expected beats of one command, table updated along the way
    function automatic void predict_command(bptm_pkg::in_item_t cmd);
        bptm_pkg::out_item_t st;
        int                  i;
        st      = '0;
        st.last = 1'b1;
        case (cmd.kind)
            bptm_pkg::KIND_ADD: begin
                // duplicates only count before the first hole
                i = 0;
                while (i < ENTRIES && bp_address[i] != '0 && bp_address[i] != cmd.address)
                    i++;
                if (i < ENTRIES && bp_address[i] != '0) begin
                    st.status = bptm_pkg::STATUS_DUPLICATE;
                end else if (i == ENTRIES) begin
                    st.status = bptm_pkg::STATUS_FULL;
                end else if (!cmd.readable) begin
                    st.status = bptm_pkg::STATUS_UNREADABLE;
                end else if (cmd.address != '0) begin
                    bp_address[i] = cmd.address;
                    bp_saved[i]   = cmd.current_byte;
                    bp_flags[i]   = cmd.attr_flags;
                end
            end
            bptm_pkg::KIND_CLEAR_SLOT: begin
                if (cmd.slot < ENTRIES)
                    clear_breakpoint(int'(cmd.slot));
            end
            bptm_pkg::KIND_CLEAR_TEMP: begin
                for (i = 0; i < ENTRIES; i++)
                    if (bp_flags[i][bptm_pkg::FLAG_TMP])
                        clear_breakpoint(i);
            end
            bptm_pkg::KIND_FIND: begin
                // address zero never matches an empty entry
                if (cmd.address != '0)
                    for (i = 0; i < ENTRIES; i++)
                        if (!st.found && bp_address[i] == cmd.address) begin
                            st.found = 1'b1;
                            st.index = 4'(i);
                        end
            end
            bptm_pkg::KIND_HIDE_ALL: begin
                for (i = 0; i < ENTRIES; i++)
                    if (bp_address[i] != '0)
                        expected_beats.push_back(write_beat(bp_address[i], bp_saved[i]));
            end
            bptm_pkg::KIND_REFRESH_ALL: begin
                for (i = 0; i < ENTRIES; i++)
                    if (bp_address[i] != '0 && !bp_flags[i][bptm_pkg::FLAG_DIS])
                        expected_beats.push_back(write_beat(bp_address[i],
                                                            bptm_pkg::TRAP_BYTE));
            end
            bptm_pkg::KIND_CLEAR_ALL: begin
                for (i = 0; i < ENTRIES; i++)
                    clear_breakpoint(i);
            end
            default: begin
            end
        endcase
        expected_beats.push_back(st);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_beat(input bptm_pkg::out_item_t got);
        bptm_pkg::out_item_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: %p", got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.is_write !== want.is_write)
            report_mismatch($sformatf("is_write %b, expected %b", got.is_write, want.is_write));
        if (got.write_address !== want.write_address)
            report_mismatch($sformatf("write_address %h, expected %h",
                                      got.write_address, want.write_address));
        if (got.write_data !== want.write_data)
            report_mismatch($sformatf("write_data %h, expected %h",
                                      got.write_data, want.write_data));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
        if (got.index !== want.index)
            report_mismatch($sformatf("index %0d, expected %0d", got.index, want.index));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    // watch both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                bp_address[i] = '0;
                bp_saved[i]   = '0;
                bp_flags[i]   = '0;
            end
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_beat(m_data);
                if (m_data.is_write === 1'b1)
                    write_count++;
            end
            if (s_valid && s_ready) begin
                predict_command(s_data);
                command_count++;
            end
        end
        pending_count = expected_beats.size();
    end

endmodule

### verif/tb.sv
module tb;

    localparam int          NUM_ENTRIES  = 16;
    localparam int          POOL_SIZE    = 24;
    localparam int          RANDOM_ITEMS = 306;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_TOGGLE,
        READY_RUNS
    } ready_mode_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bptm_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bptm_pkg::out_item_t m_data;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned command_count;
    int unsigned write_count;

    int unsigned cycle_count = 0;
    int unsigned sent_count  = 0;
    int unsigned burst_left  = 1;
    int unsigned fill_count  = 0;
    logic [31:0] addr_pool [POOL_SIZE];

    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;

    breakpoint_table_manager #(
        .ENTRIES (NUM_ENTRIES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bptm_checker #(
        .ENTRIES (NUM_ENTRIES)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .command_count  (command_count),
        .write_count    (write_count)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, pending_count);
            $display("** breakpoint_table_manager: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure in a randomly chosen mode that changes over the run
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            READY_TOGGLE: m_ready <= ~m_ready;
            default: begin
                // runs of ready and stall of random length
                if (hold_left == 0) begin
                    m_ready   <= ~m_ready;
                    hold_left <= $urandom_range(1, 8);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    function automatic bptm_pkg::in_item_t make_cmd(logic [2:0] kind, logic [31:0] addr,
                                                    logic [7:0] slot, logic [1:0] attr,
                                                    logic readable, logic [7:0] cur);
        bptm_pkg::in_item_t c;
        c.kind         = kind;
        c.address      = addr;
        c.slot         = slot;
        c.attr_flags   = attr;
        c.readable     = readable;
        c.current_byte = cur;
        return c;
    endfunction

    // mostly pool addresses so adds collide and finds hit
    function automatic bptm_pkg::in_item_t random_command();
        bptm_pkg::in_item_t c;
        int unsigned        pick;
        int unsigned        sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            c.address = '0;
        else if (sel < 14)
            c.address = $urandom;
        else
            c.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        c.slot         = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, NUM_ENTRIES - 1))
                                                     : 8'($urandom_range(0, 255));
        c.attr_flags   = 2'($urandom_range(0, 3));
        c.readable     = ($urandom_range(0, 9) != 0);
        c.current_byte = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 42)      c.kind = bptm_pkg::KIND_ADD;
        else if (pick < 62) c.kind = bptm_pkg::KIND_FIND;
        else if (pick < 72) c.kind = bptm_pkg::KIND_CLEAR_SLOT;
        else if (pick < 79) c.kind = bptm_pkg::KIND_CLEAR_TEMP;
        else if (pick < 86) c.kind = bptm_pkg::KIND_HIDE_ALL;
        else if (pick < 93) c.kind = bptm_pkg::KIND_REFRESH_ALL;
        else if (pick < 97) c.kind = bptm_pkg::KIND_CLEAR_ALL;
        else                c.kind = bptm_pkg::KIND_UNUSED;
        return c;
    endfunction

    // send one command beat; bursts end with a random gap
    task automatic send_command(input bptm_pkg::in_item_t cmd);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // wipe, fill every entry, then hit the full table
    task automatic fill_table();
        int unsigned base;
        int          j;
        base = $urandom_range(0, POOL_SIZE - 1);
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_ALL, $urandom, 8'($urandom_range(0, 255)),
                              2'd0, 1'b1, 8'h00));
        for (j = 0; j < NUM_ENTRIES + 2; j++)
            send_command(make_cmd(bptm_pkg::KIND_ADD, addr_pool[(base + j) % POOL_SIZE],
                                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                                  1'b1, 8'($urandom_range(0, 255))));
        // duplicate wins over full
        send_command(make_cmd(bptm_pkg::KIND_ADD, addr_pool[base], 8'd0, 2'd0, 1'b1, 8'h11));
        fill_count++;
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = $urandom;
            if (addr_pool[i] == '0)
                addr_pool[i] = 32'h1;
        end

        // reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, every command and corner
        send_command(make_cmd(bptm_pkg::KIND_FIND,        32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_HIDE_ALL,    32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_REFRESH_ALL, 32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_0000, 8'd0,   2'd3, 1'b1,
                              8'h77));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_0001, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_0001, 8'd0,   2'd0, 1'b1,
                              8'h33));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'hFFFF_FFFF, 8'hFF,  2'd3, 1'b1,
                              8'hFF));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h8000_0000, 8'd0,   2'd0, 1'b0,
                              8'h12));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_3000, 8'd0,   2'd1, 1'b1,
                              8'h5A));
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_4000, 8'd0,   2'd2, 1'b1,
                              8'hA5));
        send_command(make_cmd(bptm_pkg::KIND_FIND,        32'hFFFF_FFFF, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_FIND,        32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_FIND,        32'h1234_5678, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_REFRESH_ALL, 32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_HIDE_ALL,    32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_TEMP,  32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_SLOT,  32'h0000_0000, 8'd255, 2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_SLOT,  32'h0000_0000, 8'(NUM_ENTRIES), 2'd0,
                              1'b1, 8'h00));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_SLOT,  32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_SLOT,  32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        // lands in the hole at entry 0 although entry 3 holds the same address
        send_command(make_cmd(bptm_pkg::KIND_ADD,         32'h0000_4000, 8'd0,   2'd0, 1'b1,
                              8'hC3));
        send_command(make_cmd(bptm_pkg::KIND_FIND,        32'h0000_4000, 8'd0,   2'd0, 1'b1,
                              8'h00));
        send_command(make_cmd(bptm_pkg::KIND_UNUSED,      32'hDEAD_BEEF, 8'd9,   2'd3, 1'b0,
                              8'h99));
        send_command(make_cmd(bptm_pkg::KIND_CLEAR_ALL,   32'h0000_0000, 8'd0,   2'd0, 1'b1,
                              8'h00));

        // random traffic with occasional full-table episodes
        fill_table();
        while (sent_count < 24 + RANDOM_ITEMS) begin
            if ($urandom_range(0, 59) == 0)
                fill_table();
            else
                send_command(random_command());
        end

        // drain
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d commands and %0d memory write beats in %0d cycles",
                 command_count, write_count, cycle_count);
        $display("table filled to capacity %0d times under random gaps and stalls",
                 fill_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("** breakpoint_table_manager: PASSED **");
        end else begin
            $display("** breakpoint_table_manager: FAILED **");
        end
        $finish;
    end

endmodule
